>>> hw/rtl/c8ex_pkg.sv
// Shared types and constants for the 8-bit execute stage: operation codes,
// flag bit positions, architectural register and result structs. No dependencies.
`default_nettype none

package c8ex_pkg;

	typedef enum logic [5:0] {
		OP_LDA   = 6'd0,  OP_LDX   = 6'd1,  OP_LDY   = 6'd2,
		OP_STA   = 6'd3,  OP_STX   = 6'd4,  OP_STY   = 6'd5,
		OP_TAX   = 6'd6,  OP_TAY   = 6'd7,  OP_TXA   = 6'd8,
		OP_TYA   = 6'd9,  OP_TSX   = 6'd10, OP_TXS   = 6'd11,
		OP_PHA   = 6'd12, OP_PHP   = 6'd13, OP_PLA   = 6'd14,
		OP_PLP   = 6'd15, OP_AND   = 6'd16, OP_EOR   = 6'd17,
		OP_ORA   = 6'd18, OP_BIT   = 6'd19, OP_ADC   = 6'd20,
		OP_SBC   = 6'd21, OP_CMP   = 6'd22, OP_CPX   = 6'd23,
		OP_CPY   = 6'd24, OP_INC   = 6'd25, OP_INX   = 6'd26,
		OP_INY   = 6'd27, OP_DEC   = 6'd28, OP_DEX   = 6'd29,
		OP_DEY   = 6'd30, OP_ASL_A = 6'd31, OP_ASL_M = 6'd32,
		OP_LSR_A = 6'd33, OP_LSR_M = 6'd34, OP_ROL_A = 6'd35,
		OP_ROL_M = 6'd36, OP_ROR_A = 6'd37, OP_ROR_M = 6'd38,
		OP_BCC   = 6'd39, OP_BCS   = 6'd40, OP_BNE   = 6'd41,
		OP_BEQ   = 6'd42, OP_BPL   = 6'd43, OP_BMI   = 6'd44,
		OP_BVC   = 6'd45, OP_BVS   = 6'd46, OP_CLC   = 6'd47,
		OP_CLD   = 6'd48, OP_CLI   = 6'd49, OP_CLV   = 6'd50,
		OP_SEC   = 6'd51, OP_SED   = 6'd52, OP_SEI   = 6'd53,
		OP_NOP   = 6'd54
	} op_t;

	// status bit positions
	localparam int unsigned FLAG_N = 7;
	localparam int unsigned FLAG_V = 6;
	localparam int unsigned FLAG_U = 5;
	localparam int unsigned FLAG_B = 4;
	localparam int unsigned FLAG_D = 3;
	localparam int unsigned FLAG_I = 2;
	localparam int unsigned FLAG_Z = 1;
	localparam int unsigned FLAG_C = 0;

	localparam logic [7:0] SP_RESET   = 8'hFF;
	localparam logic [7:0] PUSH_MARKS = 8'h30; // U and B as pushed/pulled
	localparam logic       STACK_PAGE = 1'b1;  // page one

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] sp;
		logic [7:0] p;
	} regs_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic [7:0] status_flags;
		logic       branch_taken;
		logic [8:0] stack_addr;
	} res_t;

endpackage

`default_nettype wire

>>> hw/rtl/c8ex_if.sv
// Valid/ready channel interfaces for the execute stage: operation in, result out.
// Stand-alone; widths fixed by the item fields.
`default_nettype none

interface c8ex_in_if;
	logic       valid;
	logic       ready;
	logic [5:0] opcode;
	logic [7:0] operand_byte;

	modport source (output valid, output opcode, output operand_byte, input ready);
	modport sink (input valid, input opcode, input operand_byte, output ready);
endinterface

interface c8ex_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic [7:0] status_flags;
	logic       branch_taken;
	logic [8:0] stack_addr;

	modport source (output valid, output result_byte, output status_flags,
		output branch_taken, output stack_addr, input ready);
	modport sink (input valid, input result_byte, input status_flags,
		input branch_taken, input stack_addr, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/c8ex_alu.sv
// Combinational execute logic: next register/flag state and result for one operation.
// Depends on c8ex_pkg.
`default_nettype none

module c8ex_alu (
	input  wire c8ex_pkg::op_t  op,
	input  wire logic [7:0]     operand,
	input  wire c8ex_pkg::regs_t cur,
	output c8ex_pkg::regs_t     nxt,
	output c8ex_pkg::res_t      res
);
	import c8ex_pkg::*;

	logic [7:0] nz_val;
	logic       nz_en;
	logic       push;
	logic [7:0] sp_inc;
	logic [7:0] add_b;
	logic [8:0] add_sum;
	logic [7:0] cmp_reg;
	logic [8:0] cmp_diff;
	logic [7:0] sh_src;
	logic [7:0] sh_out;
	logic       sh_cout;
	logic       cin;

	assign cin    = cur.p[FLAG_C];
	assign sp_inc = cur.sp + 8'd1;

	// shared adder for ADC/SBC (SBC adds the complement)
	assign add_b   = (op == OP_SBC) ? ~operand : operand;
	assign add_sum = {1'b0, cur.a} + {1'b0, add_b} + {8'd0, cin};

	// shared compare subtractor
	always_comb begin
		case (op)
			OP_CPX:  cmp_reg = cur.x;
			OP_CPY:  cmp_reg = cur.y;
			default: cmp_reg = cur.a;
		endcase
	end
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, operand};

	// shifter: accumulator forms take A, memory forms the operand
	always_comb begin
		sh_src = (op == OP_ASL_A || op == OP_LSR_A || op == OP_ROL_A || op == OP_ROR_A)
			? cur.a : operand;
		case (op)
			OP_ASL_A, OP_ASL_M: begin
				sh_out  = {sh_src[6:0], 1'b0};
				sh_cout = sh_src[7];
			end
			OP_ROL_A, OP_ROL_M: begin
				sh_out  = {sh_src[6:0], cin};
				sh_cout = sh_src[7];
			end
			OP_ROR_A, OP_ROR_M: begin
				sh_out  = {cin, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
			default: begin
				sh_out  = {1'b0, sh_src[7:1]};
				sh_cout = sh_src[0];
			end
		endcase
	end

	always_comb begin
		nxt              = cur;
		res.result_byte  = 8'd0;
		res.branch_taken = 1'b0;
		nz_val           = 8'd0;
		nz_en            = 1'b0;
		push             = 1'b0;
		case (op)
			OP_LDA: begin nxt.a = operand; res.result_byte = operand; nz_val = operand; nz_en = 1'b1; end
			OP_LDX: begin nxt.x = operand; res.result_byte = operand; nz_val = operand; nz_en = 1'b1; end
			OP_LDY: begin nxt.y = operand; res.result_byte = operand; nz_val = operand; nz_en = 1'b1; end
			OP_STA: res.result_byte = cur.a;
			OP_STX: res.result_byte = cur.x;
			OP_STY: res.result_byte = cur.y;
			OP_TAX: begin nxt.x = cur.a; res.result_byte = cur.a; nz_val = cur.a; nz_en = 1'b1; end
			OP_TAY: begin nxt.y = cur.a; res.result_byte = cur.a; nz_val = cur.a; nz_en = 1'b1; end
			OP_TXA: begin nxt.a = cur.x; res.result_byte = cur.x; nz_val = cur.x; nz_en = 1'b1; end
			OP_TYA: begin nxt.a = cur.y; res.result_byte = cur.y; nz_val = cur.y; nz_en = 1'b1; end
			OP_TSX: begin nxt.x = cur.sp; res.result_byte = cur.sp; nz_val = cur.sp; nz_en = 1'b1; end
			OP_TXS: begin nxt.sp = cur.x; res.result_byte = cur.x; end
			OP_PHA: begin
				res.result_byte = cur.a;
				nxt.sp = cur.sp - 8'd1;
				push = 1'b1;
			end
			OP_PHP: begin
				res.result_byte = cur.p | PUSH_MARKS;
				nxt.sp = cur.sp - 8'd1;
				push = 1'b1;
			end
			OP_PLA: begin
				nxt.sp = sp_inc;
				nxt.a = operand;
				res.result_byte = operand;
				nz_val = operand;
				nz_en = 1'b1;
			end
			OP_PLP: begin
				nxt.sp = sp_inc;
				nxt.p = operand | PUSH_MARKS;
			end
			OP_AND: begin
				nxt.a = cur.a & operand; res.result_byte = cur.a & operand;
				nz_val = cur.a & operand; nz_en = 1'b1;
			end
			OP_EOR: begin
				nxt.a = cur.a ^ operand; res.result_byte = cur.a ^ operand;
				nz_val = cur.a ^ operand; nz_en = 1'b1;
			end
			OP_ORA: begin
				nxt.a = cur.a | operand; res.result_byte = cur.a | operand;
				nz_val = cur.a | operand; nz_en = 1'b1;
			end
			OP_BIT: begin
				nxt.p[FLAG_Z] = ((cur.a & operand) == 8'd0);
				nxt.p[FLAG_N] = operand[7];
				nxt.p[FLAG_V] = operand[6];
			end
			OP_ADC, OP_SBC: begin
				nxt.a = add_sum[7:0];
				res.result_byte = add_sum[7:0];
				nxt.p[FLAG_C] = add_sum[8];
				nxt.p[FLAG_V] = (cur.a[7] ^ add_sum[7]) & (add_b[7] ^ add_sum[7]);
				nz_val = add_sum[7:0];
				nz_en = 1'b1;
			end
			OP_CMP, OP_CPX, OP_CPY: begin
				nxt.p[FLAG_C] = ~cmp_diff[8];
				nz_val = cmp_diff[7:0];
				nz_en = 1'b1;
			end
			OP_INC: begin
				res.result_byte = operand + 8'd1; nz_val = operand + 8'd1; nz_en = 1'b1;
			end
			OP_INX: begin
				nxt.x = cur.x + 8'd1; res.result_byte = cur.x + 8'd1;
				nz_val = cur.x + 8'd1; nz_en = 1'b1;
			end
			OP_INY: begin
				nxt.y = cur.y + 8'd1; res.result_byte = cur.y + 8'd1;
				nz_val = cur.y + 8'd1; nz_en = 1'b1;
			end
			OP_DEC: begin
				res.result_byte = operand - 8'd1; nz_val = operand - 8'd1; nz_en = 1'b1;
			end
			OP_DEX: begin
				nxt.x = cur.x - 8'd1; res.result_byte = cur.x - 8'd1;
				nz_val = cur.x - 8'd1; nz_en = 1'b1;
			end
			OP_DEY: begin
				nxt.y = cur.y - 8'd1; res.result_byte = cur.y - 8'd1;
				nz_val = cur.y - 8'd1; nz_en = 1'b1;
			end
			OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
				nxt.a = sh_out; res.result_byte = sh_out;
				nxt.p[FLAG_C] = sh_cout; nz_val = sh_out; nz_en = 1'b1;
			end
			OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
				res.result_byte = sh_out;
				nxt.p[FLAG_C] = sh_cout; nz_val = sh_out; nz_en = 1'b1;
			end
			OP_BCC: res.branch_taken = ~cur.p[FLAG_C];
			OP_BCS: res.branch_taken = cur.p[FLAG_C];
			OP_BNE: res.branch_taken = ~cur.p[FLAG_Z];
			OP_BEQ: res.branch_taken = cur.p[FLAG_Z];
			OP_BPL: res.branch_taken = ~cur.p[FLAG_N];
			OP_BMI: res.branch_taken = cur.p[FLAG_N];
			OP_BVC: res.branch_taken = ~cur.p[FLAG_V];
			OP_BVS: res.branch_taken = cur.p[FLAG_V];
			OP_CLC: nxt.p[FLAG_C] = 1'b0;
			OP_CLD: nxt.p[FLAG_D] = 1'b0;
			OP_CLI: nxt.p[FLAG_I] = 1'b0;
			OP_CLV: nxt.p[FLAG_V] = 1'b0;
			OP_SEC: nxt.p[FLAG_C] = 1'b1;
			OP_SED: nxt.p[FLAG_D] = 1'b1;
			OP_SEI: nxt.p[FLAG_I] = 1'b1;
			default: ;
		endcase
		if (nz_en) begin
			nxt.p[FLAG_N] = nz_val[7];
			nxt.p[FLAG_Z] = (nz_val == 8'd0);
		end
		res.status_flags = nxt.p;
		// push reports the pointer before decrement; all else the pointer afterwards
		res.stack_addr = push ? {STACK_PAGE, cur.sp} : {STACK_PAGE, nxt.sp};
	end

endmodule

`default_nettype wire

>>> hw/rtl/cpu8_register_alu_execute.sv
// Top level of the 8-bit execute stage: input register, architectural state, result register.
// Depends on c8ex_pkg, c8ex_in_if/c8ex_out_if and c8ex_alu.
//
// Executes one register/ALU operation per transaction and returns one result per
// transaction. Throughput is one operation per clock while the result side does not
// stall: an operation is captured in the input register, executed through the ALU
// once the result register is free or draining, which updates A, X, Y, S and the
// flags, and held in the result register until taken. The only loop is the state
// feedback through the ALU. Decimal mode is held as a flag but arithmetic is
// always binary.
`default_nettype none

module cpu8_register_alu_execute (
	input  wire logic   clk,
	input  wire logic   arst_n,
	c8ex_in_if.sink     req,
	c8ex_out_if.source  rsp
);
	import c8ex_pkg::*;

	logic       valid_s1;
	logic [5:0] opcode_s1;
	logic [7:0] operand_s1;
	regs_t      regs_q;
	regs_t      regs_nxt;
	res_t       alu_res;
	res_t       rsp_q;
	logic       rsp_valid_q;
	logic       advance;

	// execute when an operation is waiting and the result register is free or draining
	assign advance   = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			opcode_s1  <= req.opcode;
			operand_s1 <= req.operand_byte;
		end
	end

	c8ex_alu u_alu (
		.op      (op_t'(opcode_s1)),
		.operand (operand_s1),
		.cur     (regs_q),
		.nxt     (regs_nxt),
		.res     (alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.a    <= 8'd0;
			regs_q.x    <= 8'd0;
			regs_q.y    <= 8'd0;
			regs_q.sp   <= SP_RESET;
			regs_q.p    <= 8'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				regs_q      <= regs_nxt;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= alu_res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.result_byte  = rsp_q.result_byte;
	assign rsp.status_flags = rsp_q.status_flags;
	assign rsp.branch_taken = rsp_q.branch_taken;
	assign rsp.stack_addr   = rsp_q.stack_addr;

	// a push leaves the pointer one lower
	a_push_dec: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (opcode_s1 == OP_PHA || opcode_s1 == OP_PHP)
		|=> regs_q.sp == $past(regs_q.sp) - 8'd1)
		else $error("stack pointer not decremented by push");

	// result status mirrors the live flags just after execution
	a_status_sync: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_q.status_flags == regs_q.p)
		else $error("reported status differs from flag register");

	// pulled status always carries the U and B marks
	a_plp_marks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && opcode_s1 == OP_PLP |=> regs_q.p[FLAG_U] && regs_q.p[FLAG_B])
		else $error("pulled status lost U/B marks");

	// a branch never writes a byte back
	a_branch_res: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.branch_taken |-> rsp_q.result_byte == 8'd0)
		else $error("branch transaction with non-zero result byte");

	// stack addresses always sit in page one
	a_page_one: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.stack_addr[8])
		else $error("stack address outside page one");

endmodule

`default_nettype wire

>>> verif/c8ex_check_pkg.sv
// Result checking for the 8-bit execute stage: a register/flag predictor and
// the queue of results it expects. Depends on c8ex_pkg.
`default_nettype none

package c8ex_check_pkg;
	import c8ex_pkg::*;

	class exec_result_checker;
		logic [7:0]  acc;
		logic [7:0]  xr;
		logic [7:0]  yr;
		logic [7:0]  sp;
		logic [7:0]  status;
		res_t        pending_results[$];
		int unsigned errors;

		function new();
			acc    = 8'h00;
			xr     = 8'h00;
			yr     = 8'h00;
			sp     = SP_RESET;
			status = 8'h00;
			errors = 0;
		endfunction

		function logic [7:0] update_nz(logic [7:0] v);
			status[FLAG_N] = v[7];
			status[FLAG_Z] = (v == 8'h00);
			return v;
		endfunction

		// binary only, D never changes the sum
		function logic [7:0] add_with_carry(logic [7:0] a, logic [7:0] b);
			logic [8:0] sum;
			sum = {1'b0, a} + {1'b0, b} + {8'h00, status[FLAG_C]};
			status[FLAG_C] = sum[8];
			status[FLAG_V] = (a[7] ^ sum[7]) & (b[7] ^ sum[7]);
			return update_nz(sum[7:0]);
		endfunction

		function void compare_with(logic [7:0] r, logic [7:0] m);
			status[FLAG_C] = (r >= m);
			void'(update_nz(8'(r - m)));
		endfunction

		function logic [7:0] shift_byte(logic [5:0] code, logic [7:0] v);
			logic       left;
			logic       carry_in;
			logic [7:0] r;
			left = (code == OP_ASL_A) || (code == OP_ASL_M) ||
				(code == OP_ROL_A) || (code == OP_ROL_M);
			carry_in = status[FLAG_C] & ((code == OP_ROL_A) || (code == OP_ROL_M) ||
				(code == OP_ROR_A) || (code == OP_ROR_M));
			if (left) begin
				status[FLAG_C] = v[7];
				r = {v[6:0], carry_in};
			end else begin
				status[FLAG_C] = v[0];
				r = {carry_in, v[7:1]};
			end
			return update_nz(r);
		endfunction

		// advance the register model by one accepted transaction
		function void record_op(logic [5:0] code, logic [7:0] m);
			logic [7:0] res;
			logic       taken;
			logic [8:0] saddr;
			logic       pushed;
			res    = 8'h00;
			taken  = 1'b0;
			pushed = 1'b0;
			saddr  = {STACK_PAGE, sp};
			case (code)
				OP_LDA: begin acc = update_nz(m); res = acc; end
				OP_LDX: begin xr = update_nz(m); res = xr; end
				OP_LDY: begin yr = update_nz(m); res = yr; end
				OP_STA: res = acc;
				OP_STX: res = xr;
				OP_STY: res = yr;
				OP_TAX: begin xr = update_nz(acc); res = xr; end
				OP_TAY: begin yr = update_nz(acc); res = yr; end
				OP_TXA: begin acc = update_nz(xr); res = acc; end
				OP_TYA: begin acc = update_nz(yr); res = acc; end
				OP_TSX: begin xr = update_nz(sp); res = xr; end
				OP_TXS: begin sp = xr; res = sp; end
				OP_PHA, OP_PHP: begin
					res = (code == OP_PHA) ? acc : (status | PUSH_MARKS);
					pushed = 1'b1;
					sp = sp - 8'd1;
				end
				OP_PLA, OP_PLP: begin
					sp = sp + 8'd1;
					if (code == OP_PLA) begin
						acc = update_nz(m);
						res = acc;
					end else begin
						status = m | PUSH_MARKS;
					end
				end
				OP_AND: begin acc = update_nz(acc & m); res = acc; end
				OP_EOR: begin acc = update_nz(acc ^ m); res = acc; end
				OP_ORA: begin acc = update_nz(acc | m); res = acc; end
				OP_BIT: begin
					status[FLAG_Z] = ((acc & m) == 8'h00);
					status[FLAG_N] = m[7];
					status[FLAG_V] = m[6];
				end
				OP_ADC: begin acc = add_with_carry(acc, m); res = acc; end
				OP_SBC: begin acc = add_with_carry(acc, ~m); res = acc; end
				OP_CMP: compare_with(acc, m);
				OP_CPX: compare_with(xr, m);
				OP_CPY: compare_with(yr, m);
				OP_INC: res = update_nz(8'(m + 8'd1));
				OP_INX: begin xr = update_nz(8'(xr + 8'd1)); res = xr; end
				OP_INY: begin yr = update_nz(8'(yr + 8'd1)); res = yr; end
				OP_DEC: res = update_nz(8'(m - 8'd1));
				OP_DEX: begin xr = update_nz(8'(xr - 8'd1)); res = xr; end
				OP_DEY: begin yr = update_nz(8'(yr - 8'd1)); res = yr; end
				OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
					acc = shift_byte(code, acc);
					res = acc;
				end
				OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: res = shift_byte(code, m);
				OP_BCC: taken = !status[FLAG_C];
				OP_BCS: taken = status[FLAG_C];
				OP_BNE: taken = !status[FLAG_Z];
				OP_BEQ: taken = status[FLAG_Z];
				OP_BPL: taken = !status[FLAG_N];
				OP_BMI: taken = status[FLAG_N];
				OP_BVC: taken = !status[FLAG_V];
				OP_BVS: taken = status[FLAG_V];
				OP_CLC: status[FLAG_C] = 1'b0;
				OP_CLD: status[FLAG_D] = 1'b0;
				OP_CLI: status[FLAG_I] = 1'b0;
				OP_CLV: status[FLAG_V] = 1'b0;
				OP_SEC: status[FLAG_C] = 1'b1;
				OP_SED: status[FLAG_D] = 1'b1;
				OP_SEI: status[FLAG_I] = 1'b1;
				default: ;
			endcase
			// a push reports the pointer before decrement, all else the pointer now
			if (!pushed)
				saddr = {STACK_PAGE, sp};
			pending_results.push_back({res, status, taken, saddr});
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding: %h", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.result_byte !== want.result_byte) begin
				$error("result_byte: expected %02h, actual %02h",
					want.result_byte, got.result_byte);
				errors++;
			end
			if (got.status_flags !== want.status_flags) begin
				$error("status_flags: expected %02h, actual %02h",
					want.status_flags, got.status_flags);
				errors++;
			end
			if (got.branch_taken !== want.branch_taken) begin
				$error("branch_taken: expected %0b, actual %0b",
					want.branch_taken, got.branch_taken);
				errors++;
			end
			if (got.stack_addr !== want.stack_addr) begin
				$error("stack_addr: expected %03h, actual %03h",
					want.stack_addr, got.stack_addr);
				errors++;
			end
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction
	endclass

endpackage

`default_nettype wire

>>> verif/cpu8_register_alu_execute_test.sv
// Self-checking bench for cpu8_register_alu_execute: directed corner cases then
// random operations with random stalls on both channels.
// Depends on c8ex_pkg, c8ex_in_if/c8ex_out_if and c8ex_check_pkg.
`default_nettype none

module cpu8_register_alu_execute_test;
	import c8ex_pkg::*;
	import c8ex_check_pkg::*;

	localparam int unsigned RANDOM_OPS       = 1875;
	localparam int unsigned CYCLE_LIMIT      = 1000000;
	localparam int unsigned LONG_HOLD_CYCLES = 96;
	localparam int unsigned LONG_HOLD_AFTER  = 600;
	localparam int unsigned DRAIN_CYCLES     = 8;
	localparam logic [5:0]  OP_FIRST_UNDEF   = 6'd55;
	localparam logic [5:0]  OP_LAST_UNDEF    = 6'd63;

	logic clk;
	logic arst_n;

	c8ex_in_if  req_if();
	c8ex_out_if rsp_if();

	cpu8_register_alu_execute u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	exec_result_checker exec_check;
	int unsigned ops_accepted = 0;
	int unsigned cycle_count = 0;
	bit          hold_active = 1'b0;
	bit          long_hold_done = 1'b0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly back-to-back, some short gaps, the odd long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h80;
			3: return 8'h7F;
			4: return 8'h01;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_op(logic [5:0] code, logic [7:0] m);
		req_if.valid        <= 1'b1;
		req_if.opcode       <= code;
		req_if.operand_byte <= m;
		do @(posedge clk); while (!req_if.ready);
		exec_check.record_op(code, m);
		ops_accepted++;
	endtask

	task automatic idle_req(int unsigned n);
		if (n != 0) begin
			req_if.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	initial begin
		int unsigned calm_left;
		logic [5:0]  code;
		exec_check = new();
		calm_left = 0;
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.opcode <= OP_NOP;
		req_if.operand_byte <= 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(OP_PLA, 8'h00);   // pull from reset pointer wraps to zero
		send_op(OP_PLP, 8'hFF);   // U and B forced on pull
		send_op(OP_PHP, 8'h00);
		send_op(OP_PLP, 8'h00);
		send_op(OP_LDA, 8'h7F);
		send_op(OP_ADC, 8'h01);   // signed overflow
		send_op(OP_SBC, 8'hFF);
		send_op(OP_LDX, 8'h00);
		send_op(OP_TXS, 8'hA5);
		send_op(OP_PHA, 8'h00);   // push at pointer zero wraps
		send_op(OP_TSX, 8'h00);
		send_op(OP_CMP, 8'hFF);
		send_op(OP_CPX, 8'h00);
		send_op(OP_CPY, 8'h80);
		send_op(OP_BIT, 8'hC0);
		send_op(OP_BVS, 8'h00);
		send_op(OP_BMI, 8'hFF);
		send_op(OP_INC, 8'hFF);
		send_op(OP_DEC, 8'h00);
		send_op(OP_SEC, 8'h00);
		send_op(OP_ROR_M, 8'h01);
		send_op(OP_ROL_A, 8'h00);
		send_op(OP_SED, 8'h00);
		send_op(OP_ADC, 8'h99);   // decimal flag must not change the sum
		send_op(OP_FIRST_UNDEF, 8'hFF);
		send_op(OP_LAST_UNDEF, 8'h00);

		for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
			if ($urandom_range(0, 99) < 90)
				code = 6'($urandom_range(0, int'(OP_NOP)));
			else
				code = 6'($urandom_range(int'(OP_FIRST_UNDEF), int'(OP_LAST_UNDEF)));
			send_op(code, pick_operand());
			if (calm_left == 0 && $urandom_range(0, 19) == 0)
				calm_left = $urandom_range(20, 80);
			if (calm_left != 0)
				calm_left--;
			else if (!hold_active)
				idle_req(pick_gap());
			// once mid-run: let the stage empty completely before going on
			if (i == RANDOM_OPS / 2) begin
				req_if.valid <= 1'b0;
				while (exec_check.outstanding() != 0) @(posedge clk);
			end
		end

		req_if.valid <= 1'b0;
		while (exec_check.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (exec_check.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// result side back-pressure
	initial begin
		int unsigned calm_left;
		int unsigned gap;
		calm_left = 0;
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// one long hold so the stage fills and stalls its input
			if (!long_hold_done && ops_accepted >= LONG_HOLD_AFTER) begin
				hold_active = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
				long_hold_done = 1'b1;
			end
			rsp_if.ready <= 1'b1;
			@(posedge clk);
			if (calm_left == 0 && $urandom_range(0, 29) == 0)
				calm_left = $urandom_range(20, 80);
			if (calm_left != 0) begin
				calm_left--;
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					rsp_if.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && rsp_if.valid && rsp_if.ready)
			exec_check.check_result({rsp_if.result_byte, rsp_if.status_flags,
				rsp_if.branch_taken, rsp_if.stack_addr});
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

`default_nettype wire
